@@ src/nfpa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfpa_pkg: shared types and constants for the next-fit page allocator
// Page geometry, request/response word layouts, codes and search result.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int unsigned PAGES      = 64;
  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_W     = $clog2(PAGES);
  localparam int unsigned OFF_W      = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W     = PAGE_W + OFF_W;
  localparam int unsigned CNT_W      = PAGE_W + 1;
  localparam int unsigned BYTE_W     = 8;

  // search tree: groups of GRP_N pages
  localparam int unsigned GRP_N  = 8;
  localparam int unsigned GRP_W  = $clog2(GRP_N);
  localparam int unsigned NGRP   = PAGES / GRP_N;
  localparam int unsigned NGRP_W = PAGE_W - GRP_W;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [PAGE_W-1:0]   page;
    logic [OFF_W-1:0]    offset;
    logic [BYTE_W-1:0]   write_byte;
    logic                burst_last;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [PAGE_W-1:0]   page_given;
    logic [BYTE_W-1:0]   read_byte;
    logic [CNT_W-1:0]    used_pages;
    logic                done_last;
  } rsp_t;

  typedef struct packed {
    logic                found;
    logic [PAGE_W-1:0]   page;
  } srch_t;

endpackage

@@ src/nfpa_req_if.sv @@
// ----------------------------------------------------------------------------
// nfpa_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface nfpa_req_if;
  import nfpa_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/nfpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nfpa_rsp_if: response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface nfpa_rsp_if;
  import nfpa_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/next_fit_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// next_fit_page_allocator_top: page store with next-fit page allocation
// Used-page bitmap, next-fit pointer, used count and a byte-wide page store.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                           | accepted
//  --------+-----+------------------------------------------------+----------------
//  req_i   | in  | kind, page, offset, write_byte, burst_last     | valid && ready
//  rsp_o   | out | status, page_given, read_byte, used_pages,     | valid && ready
//          |     | done_last                                      |
//
//  One request at a time. Free, write and any not-allocated error pass S_EXEC
//  and S_FINISH before the response is loaded into the output register; read
//  passes S_EXEC, S_READ (registered page memory read) and S_FINISH, allocate
//  S_EXEC, S_PICK (two-stage registered search) and S_FINISH. A new word is
//  taken as soon as the previous response sits in the output register, even
//  while the sink stalls it.
//  Reset clears bitmap, count and pointer at once (flops); the page store
//  is not cleared, fresh page contents are undefined.
// ----------------------------------------------------------------------------
module next_fit_page_allocator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  nfpa_req_if.sink     req_i,
  nfpa_rsp_if.source   rsp_o
);
  import nfpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PICK,
    S_READ,
    S_FINISH
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [PAGES-1:0]  used_q;
  logic [PAGE_W-1:0] ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  status_e           st_q;
  logic [PAGE_W-1:0] given_q;
  logic [BYTE_W-1:0] rbyte_q;

  rsp_t              out_q;
  logic              out_valid_q;
  logic              out_valid_d;

  logic [BYTE_W-1:0] mem [PAGES*PAGE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;

  logic              in_fire;
  logic              out_free;
  logic              page_used;
  srch_t             srch;

  assign req_i.ready   = (state_q == S_IDLE);
  assign in_fire       = req_i.valid && req_i.ready;
  assign out_free      = !out_valid_q || rsp_o.ready;
  assign page_used     = used_q[req_q.page];

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // output valid: drops when taken, set when a finished word is loaded
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if ((state_q == S_FINISH) && out_free) out_valid_d = 1'b1;
  end

  // next-fit search, launched in S_EXEC, result valid in S_PICK
  nfpa_next_fit u_search (
    .clk_i  (clk_i),
    .used_i (used_q),
    .ptr_i  (ptr_q),
    .srch_o (srch)
  );

  // page store: one port, read data registered
  assign addr   = {req_q.page, req_q.offset};
  assign mem_we = (state_q == S_EXEC) && (req_q.kind == KIND_WRITE) && page_used;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= req_q.write_byte;
    rdata_q <= mem[addr];
  end

  // control: sequencer, bitmap, pointer, count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;

      case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (req_q.kind)
            KIND_ALLOC: state_q <= S_PICK;
            KIND_READ:  state_q <= page_used ? S_READ : S_FINISH;
            KIND_FREE: begin
              if (page_used) begin
                used_q[req_q.page] <= 1'b0;
                cnt_q              <= cnt_q - CNT_W'(1);
              end
              state_q <= S_FINISH;
            end
            default: state_q <= S_FINISH;
          endcase
        end
        S_PICK: begin
          if (srch.found) begin
            used_q[srch.page] <= 1'b1;
            cnt_q             <= cnt_q + CNT_W'(1);
            ptr_q             <= srch.page;
          end
          state_q <= S_FINISH;
        end
        S_READ: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) req_q <= req_i.payload;
      end
      S_EXEC: begin
        st_q    <= (req_q.kind != KIND_ALLOC && !page_used) ? ST_NOT_ALLOC : ST_OK;
        given_q <= '0;
        rbyte_q <= '0;
      end
      S_PICK: begin
        if (srch.found) given_q <= srch.page;
        else            st_q    <= ST_FULL;
      end
      S_READ: begin
        rbyte_q <= rdata_q;
      end
      S_FINISH: begin
        if (out_free) begin
          out_q.status     <= st_q;
          out_q.page_given <= given_q;
          out_q.read_byte  <= rbyte_q;
          out_q.used_pages <= cnt_q;
          out_q.done_last  <= req_q.burst_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/nfpa_next_fit.sv @@
// ----------------------------------------------------------------------------
// nfpa_next_fit: two-stage rotating priority search over the used map
// Stage 1 rotates the free mask to the pointer and summarizes each group;
// stage 2 picks the first group and forms the absolute page number.
// ----------------------------------------------------------------------------
module nfpa_next_fit (
  input  logic                        clk_i,
  input  logic [nfpa_pkg::PAGES-1:0]  used_i,
  input  logic [nfpa_pkg::PAGE_W-1:0] ptr_i,
  output nfpa_pkg::srch_t             srch_o
);
  import nfpa_pkg::*;

  logic [PAGES-1:0]  rot;
  logic [NGRP-1:0]   any_d, any_q;
  logic [GRP_W-1:0]  idx_d [NGRP];
  logic [GRP_W-1:0]  idx_q [NGRP];
  logic [PAGE_W-1:0] ptr_q;
  logic [NGRP_W-1:0] sel;

  // rot[i] = page (ptr + i) is free
  always_comb begin
    rot = PAGES'({~used_i, ~used_i} >> ptr_i);
    for (int g = 0; g < NGRP; g++) begin
      any_d[g] = |rot[g*GRP_N +: GRP_N];
      idx_d[g] = '0;
      for (int b = GRP_N - 1; b >= 0; b--) begin
        if (rot[g*GRP_N + b]) idx_d[g] = GRP_W'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    any_q <= any_d;
    idx_q <= idx_d;
    ptr_q <= ptr_i;
  end

  always_comb begin
    sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_q[g]) sel = NGRP_W'(g);
    end
    srch_o.found = |any_q;
    srch_o.page  = ptr_q + {sel, idx_q[sel]};
  end

endmodule

@@ bench/page_alloc_checker.sv @@
// ----------------------------------------------------------------------------
// page_alloc_checker: response predictor and comparator for the allocator
// Watches both channels, predicts each response from a shadow of the
// bitmap, next-fit pointer, used count and page bytes, compares in order.
// ----------------------------------------------------------------------------
module page_alloc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nfpa_req_if  req_i,
  nfpa_rsp_if  rsp_i,
  output int   mismatches_o,
  output int   awaiting_o
);
  import nfpa_pkg::*;

  // shadow state
  logic              page_busy [PAGES];
  logic [PAGE_W-1:0] hunt_ptr;
  logic [CNT_W-1:0]  busy_count;
  logic [BYTE_W-1:0] page_mem [PAGES*PAGE_BYTES];

  rsp_t due_q [$];
  rsp_t want;
  rsp_t got;
  int   mismatch_cnt = 0;
  int   rsp_seen = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < 100) $display("%0t: response %0d: %s", $realtime, rsp_seen, what);
    mismatch_cnt++;
  endtask

  // Applies one request to the shadow state and returns its response word.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t              o;
    logic [PAGE_W-1:0] p;
    logic              hit;
    o = '0;
    o.done_last = r.burst_last;
    if (r.kind == KIND_ALLOC) begin
      hit = 1'b0;
      p   = hunt_ptr;
      for (int n = 0; n < PAGES; n++) begin
        if (!page_busy[p]) begin
          hit = 1'b1;
          break;
        end
        p = p + 1'b1;
      end
      if (hit) begin
        page_busy[p] = 1'b1;
        busy_count   = busy_count + 1'b1;
        hunt_ptr     = p;
        for (int b = 0; b < PAGE_BYTES; b++) page_mem[p*PAGE_BYTES + b] = '0;
        o.page_given = p;
      end else begin
        o.status = ST_FULL;
      end
    end else if (!page_busy[r.page]) begin
      o.status = ST_NOT_ALLOC;
    end else begin
      case (r.kind)
        KIND_FREE: begin
          page_busy[r.page] = 1'b0;
          busy_count        = busy_count - 1'b1;
        end
        KIND_READ: begin
          o.read_byte = page_mem[{r.page, r.offset}];
        end
        default: begin
          page_mem[{r.page, r.offset}] = r.write_byte;
        end
      endcase
    end
    o.used_pages = busy_count;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAGES; i++) page_busy[i] = 1'b0;
      hunt_ptr   = '0;
      busy_count = '0;
      due_q.delete();
      awaiting_o = 0;
    end else begin
      // response side first: a request taken at this edge cannot have its
      // response out at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.payload;
        if (due_q.size() == 0) begin
          report_mismatch("response word with no request outstanding");
        end else begin
          want = due_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.page_given !== want.page_given)
            report_mismatch($sformatf("page_given %0d, expected %0d",
                                      got.page_given, want.page_given));
          if (got.read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte %0h, expected %0h",
                                      got.read_byte, want.read_byte));
          if (got.used_pages !== want.used_pages)
            report_mismatch($sformatf("used_pages %0d, expected %0d",
                                      got.used_pages, want.used_pages));
          if (got.done_last !== want.done_last)
            report_mismatch($sformatf("done_last %0b, expected %0b",
                                      got.done_last, want.done_last));
        end
        rsp_seen++;
      end
      if (req_i.valid && req_i.ready) due_q.push_back(serve_request(req_i.payload));
      awaiting_o = due_q.size();
    end
  end

endmodule

@@ bench/tb_next_fit_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_next_fit_page_allocator_top: testbench for the next-fit page allocator
// Directed words for the corner cases, then random allocate/transfer/free
// sequences with idling on both channels and one long response hold-off.
// Checking lives in page_alloc_checker; this module drives and judges.
// ----------------------------------------------------------------------------
module tb_next_fit_page_allocator_top;
  import nfpa_pkg::*;

  localparam int TOTAL_WORDS = 1750;  // stop offering new sequences past this
  localparam int CALM_TAIL   = 150;   // last words: no idling on either side
  localparam int HOLD_AT     = 600;   // word count that triggers the long hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL  = 40;    // settle time after the last response

  logic clk_i = 1'b0;
  logic rst_ni;

  nfpa_req_if req_if ();
  nfpa_rsp_if rsp_if ();

  int mismatches;
  int pending;

  next_fit_page_allocator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  page_alloc_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .awaiting_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Stimulus-side view of the block. Only needed so that reads never touch
  // a byte that was not written since its page was allocated (contents of a
  // fresh page are undefined), and so that sequences can target live pages.
  // --------------------------------------------------------------------------
  bit                    own_used [PAGES];
  logic [PAGE_BYTES-1:0] filled   [PAGES];   // bytes written since allocation
  int                    own_ptr;
  int                    own_count;

  int words_sent;
  int gap_pct;
  int gap_phase;
  bit calm;       // set near the end: both sides stop idling
  bit hold_req;   // asks the response side for one long stall

  function automatic int pick_used();
    int q [$];
    for (int i = 0; i < PAGES; i++) if (own_used[i]) q.push_back(i);
    if (q.size() == 0) return -1;
    return q[$urandom_range(0, q.size() - 1)];
  endfunction

  // Offers one word; returns at the falling edge after it was taken.
  // valid stays high so the next word can follow without a bubble.
  task automatic put_word(input req_t w);
    req_if.payload <= w;
    req_if.valid   <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Builds a request word, updates the stimulus-side view and sends it.
  task automatic issue(input kind_e k, input int pg, input int off,
                       input int wb, input bit last);
    req_t w;
    int   g;
    // offset wraps within the page; mask keeps it non-negative
    off = off & (PAGE_BYTES - 1);
    // a read of a never-written byte of a live page is illegal: write instead
    if (k == KIND_READ && own_used[pg] && !filled[pg][off]) k = KIND_WRITE;
    w.kind       = k;
    w.page       = pg[PAGE_W-1:0];
    w.offset     = off[OFF_W-1:0];
    w.write_byte = wb[BYTE_W-1:0];
    w.burst_last = last;

    case (k)
      KIND_ALLOC: begin
        for (int n = 0; n < PAGES; n++) begin
          g = (own_ptr + n) % PAGES;
          if (!own_used[g]) begin
            own_used[g] = 1'b1;
            own_count++;
            own_ptr   = g;
            filled[g] = '0;
            break;
          end
        end
      end
      KIND_FREE: begin
        if (own_used[pg]) begin
          own_used[pg] = 1'b0;
          own_count--;
        end
      end
      KIND_WRITE: begin
        if (own_used[pg]) filled[pg][off] = 1'b1;
      end
      default: ;
    endcase

    // sender idling: phases of different density, idle bursts between words
    if (gap_phase == 0) begin
      gap_phase = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
    end
    gap_phase--;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end

    if (words_sent == HOLD_AT) hold_req = 1'b1;
    put_word(w);
    words_sent++;
    if (words_sent >= TOTAL_WORDS - CALM_TAIL) calm = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Random sequences
  // --------------------------------------------------------------------------

  // Allocate a page (freeing one first if full), write a run of bytes, read most of it back, maybe free it.
  task automatic page_transfer();
    int g;
    int len;
    int start;
    g = pick_used();
    if (own_count == PAGES) issue(KIND_FREE, g, $urandom, $urandom, $urandom_range(0, 1));
    issue(KIND_ALLOC, $urandom_range(0, PAGES - 1), $urandom, $urandom, $urandom_range(0, 1));
    g     = own_ptr;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
    start = $urandom_range(0, PAGE_BYTES - 1);
    for (int i = 0; i < len; i++)
      issue(KIND_WRITE, g, start + i, $urandom, i == len - 1);
    for (int i = 0; i < len; i++)
      if ($urandom_range(0, 4) != 0) issue(KIND_READ, g, start + i, $urandom, i == len - 1);
    if ($urandom_range(0, 9) < 6) issue(KIND_FREE, g, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // Mixed reads and writes on a page that is already live; with none live, one write to an arbitrary page.
  task automatic revisit();
    int p;
    int n;
    p = pick_used();
    if (p < 0) begin
      issue(KIND_WRITE, $urandom_range(0, PAGES - 1), $urandom, $urandom, 1'b1);
      return;
    end
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      issue($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, p, $urandom, $urandom, i == n - 1);
  endtask

  // Fully random words of every kind: hits not-allocated errors on free, read and write.
  task automatic noise();
    repeat ($urandom_range(1, 4))
      issue(kind_e'($urandom_range(0, 3)), $urandom_range(0, PAGES - 1), $urandom,
            $urandom, $urandom_range(0, 1));
  endtask

  // Frees a few pages, live ones and arbitrary numbers alike.
  task automatic release_some();
    int p;
    repeat ($urandom_range(1, (own_count > 40) ? 8 : 4)) begin
      p = pick_used();
      if (p < 0 || $urandom_range(0, 2) == 0) p = $urandom_range(0, PAGES - 1);
      issue(KIND_FREE, p, $urandom, $urandom, $urandom_range(0, 1));
    end
  endtask

  // Allocates until the store is full, then asks again to see it refuse.
  task automatic fill_up();
    while (own_count < PAGES)
      issue(KIND_ALLOC, $urandom_range(0, PAGES - 1), $urandom, $urandom, $urandom_range(0, 1));
    repeat ($urandom_range(1, 2))
      issue(KIND_ALLOC, $urandom_range(0, PAGES - 1), $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready with random stall bursts, plus the long hold-off.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int stall_pct;
    int phase_left;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    stall_pct    = 0;
    phase_left   = 0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      phase_left--;
      if (hold_req) begin
        // long stretch with ready low: block fills and pushes back on requests
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb_next_fit_page_allocator_top: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Reset, directed words, random sequences, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    for (int i = 0; i < PAGES; i++) begin
      own_used[i] = 1'b0;
      filled[i]   = '0;
    end
    own_ptr    = 0;
    own_count  = 0;
    words_sent = 0;
    gap_pct    = 0;
    gap_phase  = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first allocate from empty lands on page 0; page field is ignored
    issue(KIND_ALLOC, 63, 8'hff, 8'hff, 1'b1);
    // byte extremes at both ends of the page
    issue(KIND_WRITE, 0, 8'h00, 8'h00, 1'b0);
    issue(KIND_WRITE, 0, 8'hff, 8'hff, 1'b1);
    issue(KIND_READ,  0, 8'h00, 8'hff, 1'b0);
    issue(KIND_READ,  0, 8'hff, 8'h00, 1'b1);
    // page not in use: free, read and write all refused
    issue(KIND_FREE,  63, 8'h00, 8'h00, 1'b0);
    issue(KIND_READ,  63, 8'h55, 8'h00, 1'b1);
    issue(KIND_WRITE, 63, 8'haa, 8'ha5, 1'b0);
    // next fit: pointer follows the last page given, so search moves on to 1, then 2
    // even after page 0 was freed
    issue(KIND_ALLOC, 0, 8'h00, 8'h00, 1'b0);
    issue(KIND_FREE,  0, 8'h00, 8'h00, 1'b1);
    issue(KIND_ALLOC, 0, 8'h00, 8'h00, 1'b0);
    issue(KIND_READ,  0, 8'h00, 8'h00, 1'b0);
    issue(KIND_ALLOC, 42, 8'h00, 8'h00, 1'b1);
    // back to empty, count returns to zero
    issue(KIND_FREE,  1, 8'h00, 8'h00, 1'b0);
    issue(KIND_FREE,  2, 8'h00, 8'h00, 1'b0);
    issue(KIND_FREE,  3, 8'h00, 8'h00, 1'b1);
    // pointer page itself free again: reused at once
    issue(KIND_ALLOC, 0, 8'h00, 8'h00, 1'b0);
    issue(KIND_WRITE, 3, 8'h80, 8'h5a, 1'b0);
    issue(KIND_READ,  3, 8'h80, 8'h00, 1'b1);
    issue(KIND_FREE,  3, 8'h00, 8'h00, 1'b0);

    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      page_transfer();
      else if (pick < 60) revisit();
      else if (pick < 72) noise();
      else if (pick < 96) release_some();
      else                fill_up();
    end
    req_if.valid <= 1'b0;

    // let every outstanding response come back, then a short settle time
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb_next_fit_page_allocator_top: clean");
    end else begin
      $display("tb_next_fit_page_allocator_top: errors");
    end
    $finish;
  end

endmodule
